### design/mst_pkg.sv
package mst_pkg;

  localparam int NUM_SLOTS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 32;

  localparam int KIND_W     = 3;
  localparam int SLOT_W     = 4;
  localparam int VALUE_W    = 32;
  localparam int S_TDATA_W  = 72;
  localparam int M_TDATA_W  = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 3'd0,
    KIND_SETUP = 3'd1,
    KIND_START = 3'd2,
    KIND_STOP  = 3'd3,
    KIND_RESET = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_PUSH,
    ST_FLUSH
  } state_e;

endpackage

### design/mst_ram.sv
module mst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/multi_slot_software_timer_unit.sv
// Table of NUM_SLOTS one-shot or repeating timer slots. A set up, start, stop or reset
// command is applied while the unit is idle. A tick walks the slots in ascending order
// through one shared read, count-up and compare pass over the slot stores: a slot that
// is not both registered and running is passed over at the store read, one that is goes
// through store read, then evaluate and write back, and a closing step ends the walk;
// a firing slot may wait in a push step while the result side stalls. Each firing slot
// gives one result transfer in slot order, the final one with tlast set. No new item is
// taken while a tick is walking; a finished result waits in the output register
// without holding up the next item.
module multi_slot_software_timer_unit #(
  parameter int NUM_SLOTS  = mst_pkg::NUM_SLOTS_DEF,
  parameter int COUNT_BITS = mst_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [3:0] slot, [35:4] first_delay, [67:36] repeat_period, [68] repeat_req
  input  logic [mst_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [2:0] kind
  input  logic [mst_pkg::KIND_W-1:0]    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [3:0] fired_slot
  output logic [mst_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tlast
);

  import mst_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CFG_W = 2 * COUNT_BITS + 1;

  state_e                 state_q, state_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [NUM_SLOTS-1:0]   running_q, running_d;
  logic [NUM_SLOTS-1:0]   registered_q, registered_d;
  logic                   pend_valid_q, pend_valid_d;
  logic [IDX_W-1:0]       pend_slot_q, pend_slot_d;
  logic                   out_valid_q, out_valid_d;
  logic [IDX_W-1:0]       out_slot_q, out_slot_d;
  logic                   out_last_q, out_last_d;

  kind_e                  in_kind;
  logic [SLOT_W-1:0]      in_slot;
  logic [VALUE_W-1:0]     in_delay;
  logic [VALUE_W-1:0]     in_period;
  logic                   in_mode;
  logic                   slot_ok;
  logic [IDX_W-1:0]       in_addr;

  logic                   cnt_we;
  logic [IDX_W-1:0]       cnt_waddr;
  logic [COUNT_BITS-1:0]  cnt_wdata;
  logic [COUNT_BITS-1:0]  cnt_rdata;
  logic                   cfg_we;
  logic [IDX_W-1:0]       cfg_waddr;
  logic [CFG_W-1:0]       cfg_wdata;
  logic [CFG_W-1:0]       cfg_rdata;

  logic [COUNT_BITS-1:0]  cur_delay;
  logic [COUNT_BITS-1:0]  cur_period;
  logic                   cur_mode;
  logic [COUNT_BITS-1:0]  cnt_inc;
  logic                   fire;
  logic                   at_end;
  logic [IDX_W-1:0]       idx_next;
  logic                   out_free;

  assign in_kind   = kind_e'(s_axis_tuser);
  assign in_slot   = s_axis_tdata[3:0];
  assign in_delay  = s_axis_tdata[35:4];
  assign in_period = s_axis_tdata[67:36];
  assign in_mode   = s_axis_tdata[68];
  assign slot_ok   = int'(in_slot) < NUM_SLOTS;
  assign in_addr   = IDX_W'(in_slot);

  assign cur_delay  = cfg_rdata[COUNT_BITS-1:0];
  assign cur_period = cfg_rdata[2*COUNT_BITS-1:COUNT_BITS];
  assign cur_mode   = cfg_rdata[2*COUNT_BITS];
  assign cnt_inc    = cnt_rdata + COUNT_BITS'(1);
  assign fire       = cnt_inc >= cur_delay;

  assign at_end   = idx_q == IDX_W'(NUM_SLOTS - 1);
  assign idx_next = idx_q + IDX_W'(1);
  assign out_free = !out_valid_q || m_axis_tready;

  mst_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(NUM_SLOTS)
  ) u_cnt_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(cnt_waddr),
    .wdata_i(cnt_wdata),
    .raddr_i(idx_q),
    .rdata_o(cnt_rdata)
  );

  mst_ram #(
    .WIDTH(CFG_W),
    .DEPTH(NUM_SLOTS)
  ) u_cfg_ram (
    .clk_i  (clk_i),
    .we_i   (cfg_we),
    .waddr_i(cfg_waddr),
    .wdata_i(cfg_wdata),
    .raddr_i(idx_q),
    .rdata_o(cfg_rdata)
  );

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    running_d    = running_q;
    registered_d = registered_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    out_valid_d  = out_valid_q;
    out_slot_d   = out_slot_q;
    out_last_d   = out_last_q;
    cnt_we       = 1'b0;
    cnt_waddr    = idx_q;
    cnt_wdata    = '0;
    cfg_we       = 1'b0;
    cfg_waddr    = idx_q;
    cfg_wdata    = {cur_mode, cur_period, cur_period};

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (in_kind == KIND_TICK) begin
            idx_d   = '0;
            state_d = ST_READ;
          end else if (slot_ok) begin
            unique case (in_kind)
              KIND_SETUP: begin
                cfg_we                = 1'b1;
                cfg_waddr             = in_addr;
                cfg_wdata             = {in_mode, COUNT_BITS'(in_period),
                                         COUNT_BITS'(in_delay)};
                cnt_we                = 1'b1;
                cnt_waddr             = in_addr;
                running_d[in_addr]    = 1'b0;
                registered_d[in_addr] = 1'b1;
              end
              KIND_START: running_d[in_addr] = 1'b1;
              KIND_STOP:  running_d[in_addr] = 1'b0;
              KIND_RESET: begin
                cnt_we             = 1'b1;
                cnt_waddr          = in_addr;
                running_d[in_addr] = 1'b1;
              end
              default: ;
            endcase
          end
        end
      end
      ST_READ: begin
        if (registered_q[idx_q] && running_q[idx_q]) begin
          state_d = ST_EVAL;
        end else begin
          idx_d   = idx_next;
          state_d = at_end ? ST_FLUSH : ST_READ;
        end
      end
      ST_EVAL: begin
        cnt_we    = 1'b1;
        cnt_wdata = (fire && cur_mode) ? '0 : cnt_inc;
        cfg_we    = fire && cur_mode;
        if (fire && !cur_mode) begin
          running_d[idx_q] = 1'b0;
        end
        if (fire && pend_valid_q && !out_free) begin
          state_d = ST_PUSH;
        end else begin
          if (fire) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_slot_d  = pend_slot_q;
              out_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_slot_d  = idx_q;
          end
          idx_d   = idx_next;
          state_d = at_end ? ST_FLUSH : ST_READ;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_slot_d  = pend_slot_q;
          out_last_d  = 1'b0;
          pend_slot_d = idx_q;
          idx_d       = idx_next;
          state_d     = at_end ? ST_FLUSH : ST_READ;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_slot_d   = pend_slot_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      running_q    <= '0;
      registered_q <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      running_q    <= running_d;
      registered_q <= registered_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_slot_q <= pend_slot_d;
    out_slot_q  <= out_slot_d;
    out_last_q  <= out_last_d;
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(SLOT_W'(out_slot_q));
  assign m_axis_tlast  = out_last_q;

endmodule

### design/mst_checker.sv
module mst_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [mst_pkg::KIND_W-1:0]    s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [mst_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);

  import mst_pkg::*;

  logic s_xfer;
  logic s_tick;

  assign s_xfer = s_axis_tvalid && s_axis_tready;
  assign s_tick = s_xfer && (s_axis_tuser == KIND_TICK);

  // a tick occupies the walk, so input stays closed in the next cycle
  tick_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tick |=> !s_axis_tready)
    else $error("input open right after a tick transfer");

  // commands never create results
  cmd_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && !s_tick && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared after a command transfer");

  // when the walk ends only a closing result may still wait
  walk_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready) |-> !m_axis_tvalid || m_axis_tlast)
    else $error("non-final result waiting at end of tick");

  out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind multi_slot_software_timer_unit mst_checker u_mst_checker (.*);
